>>> design/mat3_inverse_determinant_assert.svh
// assertion macros for the 3x3 inverse block checker
`ifndef MAT3_INVERSE_DETERMINANT_ASSERT_SVH
`define MAT3_INVERSE_DETERMINANT_ASSERT_SVH

// same-cycle implication, disabled while rst is high
`define MAT3I_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("mat3i assertion failed");

// next-cycle implication, disabled while rst is high
`define MAT3I_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("mat3i assertion failed");

`endif

>>> design/mat3i_pkg.sv
// shared types and constants for the 3x3 inverse block
`default_nettype none
package mat3i_pkg;

  localparam int ELEM_W = 32;
  localparam int NUM_W  = 98;
  localparam int LANES  = 9;
  localparam int Q_W    = 32;
  localparam int EPS_W  = 31;

  typedef struct packed {
    logic signed [ELEM_W-1:0] e_r0c0;
    logic signed [ELEM_W-1:0] e_r0c1;
    logic signed [ELEM_W-1:0] e_r0c2;
    logic signed [ELEM_W-1:0] e_r1c0;
    logic signed [ELEM_W-1:0] e_r1c1;
    logic signed [ELEM_W-1:0] e_r1c2;
    logic signed [ELEM_W-1:0] e_r2c0;
    logic signed [ELEM_W-1:0] e_r2c1;
    logic signed [ELEM_W-1:0] e_r2c2;
  } mat_in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] inv_r0c0;
    logic signed [ELEM_W-1:0] inv_r0c1;
    logic signed [ELEM_W-1:0] inv_r0c2;
    logic signed [ELEM_W-1:0] inv_r1c0;
    logic signed [ELEM_W-1:0] inv_r1c1;
    logic signed [ELEM_W-1:0] inv_r1c2;
    logic signed [ELEM_W-1:0] inv_r2c0;
    logic signed [ELEM_W-1:0] inv_r2c1;
    logic signed [ELEM_W-1:0] inv_r2c2;
    logic signed [ELEM_W-1:0] determinant;
    logic                     singular;
    logic                     saturated;
  } mat_out_t;

  // state carried through the divider stages
  typedef struct packed {
    logic [LANES-1:0][NUM_W-1:0] rem;
    logic [LANES-1:0][Q_W-1:0]   quo;
    logic [LANES-1:0]            ovf;
    logic [LANES-1:0]            cneg;
    logic [NUM_W-1:0]            dvs;
    logic                        dneg;
    logic                        sing;
    logic [ELEM_W-1:0]           det_q;
    logic                        det_sat;
  } div_t;

endpackage
`default_nettype wire

>>> design/mat3i_front.sv
// cofactor, determinant and dividend setup stages
`default_nettype none
module mat3i_front import mat3i_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [EPS_W-1:0] eps,
  input  logic             in_valid,
  output logic             in_ready,
  input  mat_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output div_t             out_data
);

  logic signed [ELEM_W-1:0] m [LANES];
  logic signed [2*ELEM_W-1:0] pa [LANES];
  logic signed [2*ELEM_W-1:0] pb [LANES];

  logic s1_v, s2_v, s3_v, s4_v, s5_v, s6_v;
  logic s1_adv, s2_adv, s3_adv, s4_adv, s5_adv, s6_adv;

  logic signed [2*ELEM_W-1:0] s1_pa [LANES];
  logic signed [2*ELEM_W-1:0] s1_pb [LANES];
  logic signed [ELEM_W-1:0]   s1_col [3];
  logic signed [2*ELEM_W-1:0] s2_cof [LANES];
  logic signed [ELEM_W-1:0]   s2_col [3];
  logic signed [2*ELEM_W-1:0] s3_cof [LANES];
  logic signed [2*ELEM_W:0]   s3_plo [3];
  logic signed [2*ELEM_W-1:0] s3_phi [3];
  logic signed [2*ELEM_W-1:0] s4_cof [LANES];
  logic [NUM_W-1:0]           s4_term [3];
  logic signed [2*ELEM_W-1:0] s5_cof [LANES];
  logic [NUM_W-1:0]           s5_det;
  div_t                       s6_next;
  div_t                       s6;

  // stall chain: a stage moves when empty or when the next one moves
  assign s6_adv   = !s6_v || out_ready;
  assign s5_adv   = !s5_v || s6_adv;
  assign s4_adv   = !s4_v || s5_adv;
  assign s3_adv   = !s3_v || s4_adv;
  assign s2_adv   = !s2_v || s3_adv;
  assign s1_adv   = !s1_v || s2_adv;
  assign in_ready = s1_adv;
  assign out_valid = s6_v;
  assign out_data  = s6;

  // unpack matrix and form the cofactor products
  always_comb begin
    m[0] = in_data.e_r0c0;
    m[1] = in_data.e_r0c1;
    m[2] = in_data.e_r0c2;
    m[3] = in_data.e_r1c0;
    m[4] = in_data.e_r1c1;
    m[5] = in_data.e_r1c2;
    m[6] = in_data.e_r2c0;
    m[7] = in_data.e_r2c1;
    m[8] = in_data.e_r2c2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pa[i*3+j] = m[((i+1)%3)*3 + (j+1)%3] * m[((i+2)%3)*3 + (j+2)%3];
        pb[i*3+j] = m[((i+1)%3)*3 + (j+2)%3] * m[((i+2)%3)*3 + (j+1)%3];
      end
    end
  end

  // dividends, divisor, singular test and rounded determinant
  always_comb begin
    logic [NUM_W-1:0]    mag;
    logic [NUM_W-1:0]    thr;
    logic [NUM_W-1:0]    rnd;
    logic [2*ELEM_W-1:0] c;
    logic [2*ELEM_W-1:0] cm;
    s6_next = '0;
    mag = s5_det[NUM_W-1] ? (~s5_det + 1'b1) : s5_det;
    thr = {{(NUM_W-EPS_W-ELEM_W){1'b0}}, eps, {ELEM_W{1'b0}}};
    s6_next.dneg = s5_det[NUM_W-1];
    s6_next.sing = (mag <= thr);
    s6_next.dvs  = {mag[NUM_W-2:0], 1'b0};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        c  = s5_cof[j*3+i];
        cm = c[2*ELEM_W-1] ? (~c + 1'b1) : c;
        s6_next.cneg[i*3+j] = c[2*ELEM_W-1];
        s6_next.rem[i*3+j]  = {1'b0, cm, {(ELEM_W+1){1'b0}}} + mag;
      end
    end
    rnd = s5_det + {{(NUM_W-ELEM_W){1'b0}}, 1'b1, {(ELEM_W-1){1'b0}}};
    if ((&rnd[NUM_W-1:2*ELEM_W-1]) || !(|rnd[NUM_W-1:2*ELEM_W-1])) begin
      s6_next.det_q   = rnd[2*ELEM_W-1:ELEM_W];
      s6_next.det_sat = 1'b0;
    end else begin
      s6_next.det_q   = rnd[NUM_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}}
                                     : {1'b0, {(ELEM_W-1){1'b1}}};
      s6_next.det_sat = 1'b1;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else begin
      if (s1_adv) s1_v <= in_valid;
      if (s2_adv) s2_v <= s1_v;
      if (s3_adv) s3_v <= s2_v;
      if (s4_adv) s4_v <= s3_v;
      if (s5_adv) s5_v <= s4_v;
      if (s6_adv) s6_v <= s5_v;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_pa     <= pa;
      s1_pb     <= pb;
      s1_col[0] <= m[0];
      s1_col[1] <= m[3];
      s1_col[2] <= m[6];
    end
    if (s2_adv) begin
      for (int k = 0; k < LANES; k++) s2_cof[k] <= s1_pa[k] - s1_pb[k];
      s2_col <= s1_col;
    end
    if (s3_adv) begin
      s3_cof <= s2_cof;
      for (int i = 0; i < 3; i++) begin
        s3_plo[i] <= s2_col[i] * $signed({1'b0, s2_cof[i*3][ELEM_W-1:0]});
        s3_phi[i] <= s2_col[i] * $signed(s2_cof[i*3][2*ELEM_W-1:ELEM_W]);
      end
    end
    if (s4_adv) begin
      s4_cof <= s3_cof;
      for (int i = 0; i < 3; i++) begin
        s4_term[i] <= {{(NUM_W-3*ELEM_W){s3_phi[i][2*ELEM_W-1]}}, s3_phi[i],
                       {ELEM_W{1'b0}}}
                    + {{(NUM_W-2*ELEM_W-1){s3_plo[i][2*ELEM_W]}}, s3_plo[i]};
      end
    end
    if (s5_adv) begin
      s5_cof <= s4_cof;
      s5_det <= s4_term[0] + s4_term[1] + s4_term[2];
    end
    if (s6_adv) s6 <= s6_next;
  end

endmodule
`default_nettype wire

>>> design/mat3i_div_step.sv
// one quotient bit, or the overflow check, of the nine restoring dividers
`default_nettype none
module mat3i_div_step import mat3i_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_data
);

  div_t nxt;
  div_t stage;
  logic v;

  assign in_ready  = !v || out_ready;
  assign out_valid = v;
  assign out_data  = stage;

  generate
    if (BIT == Q_W) begin : g_ovf
      // quotient does not fit in Q_W bits
      always_comb begin
        nxt = in_data;
        for (int l = 0; l < LANES; l++) begin
          nxt.ovf[l] = ((in_data.rem[l] >> BIT) >= in_data.dvs);
        end
      end
    end else begin : g_bit
      // compare shifted remainder against divisor, subtract on hit
      always_comb begin
        nxt = in_data;
        for (int l = 0; l < LANES; l++) begin
          if ((in_data.rem[l] >> BIT) >= in_data.dvs) begin
            nxt.rem[l]      = in_data.rem[l] - (in_data.dvs << BIT);
            nxt.quo[l][BIT] = 1'b1;
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) stage <= nxt;
  end

endmodule
`default_nettype wire

>>> design/mat3_inverse_determinant.sv
// top level of the pipelined 3x3 inverse and determinant block
//
//  channel   direction  handshake           payload
//  in        input      in_valid/in_stall   mat_in_t  in_data
//  out       output     out_valid/out_stall mat_out_t out_data
//  cfg       input      cfg_valid/cfg_ready singular_epsilon cfg_data
//
// one matrix per cycle sustained while out_stall stays low; pipeline registers:
// (6 setup stages, 33 divider stages, 1 output register)
// the divider stages set the depth: an overflow check, then one quotient bit per stage
// rst is synchronous and empties every stage; epsilon resets to 0
// each stage holds while the next is full and stalled, bubbles collapse
`default_nettype none
module mat3_inverse_determinant import mat3i_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  mat_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output mat_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [EPS_W-1:0] cfg_data
);

  localparam int STEPS = Q_W + 1;

  logic [EPS_W-1:0] eps;
  logic             front_ready;
  logic             out_adv;
  div_t             dchain [STEPS+1];
  logic             dvalid [STEPS+1];
  logic             dready [STEPS+1];
  div_t             fin;
  logic [ELEM_W-1:0] val [LANES];
  logic [LANES-1:0]  satl;
  mat_out_t         out_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = !front_ready;

  // epsilon register
  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= '0;
    end else if (cfg_valid && cfg_ready) begin
      eps <= cfg_data;
    end
  end

  mat3i_front u_front (
    .clk       (clk),
    .rst       (rst),
    .eps       (eps),
    .in_valid  (in_valid),
    .in_ready  (front_ready),
    .in_data   (in_data),
    .out_valid (dvalid[0]),
    .out_ready (dready[0]),
    .out_data  (dchain[0])
  );

  // divider stages, overflow check first then bits high to low
  for (genvar s = 0; s < STEPS; s++) begin : g_div
    mat3i_div_step #(.BIT(Q_W - s)) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dvalid[s]),
      .in_ready  (dready[s]),
      .in_data   (dchain[s]),
      .out_valid (dvalid[s+1]),
      .out_ready (dready[s+1]),
      .out_data  (dchain[s+1])
    );
  end

  assign fin            = dchain[STEPS];
  assign out_adv        = !out_valid || !out_stall;
  assign dready[STEPS]  = out_adv;

  // sign, clip and zero the singular case
  always_comb begin
    logic neg;
    for (int l = 0; l < LANES; l++) begin
      neg     = fin.cneg[l] ^ fin.dneg;
      val[l]  = '0;
      satl[l] = 1'b0;
      if (!fin.sing) begin
        if (fin.ovf[l] || (neg ? (fin.quo[l] > {1'b1, {(Q_W-1){1'b0}}})
                               : fin.quo[l][Q_W-1])) begin
          satl[l] = 1'b1;
          val[l]  = neg ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
        end else begin
          val[l] = neg ? (~fin.quo[l] + 1'b1) : fin.quo[l];
        end
      end
    end
    out_next.inv_r0c0    = val[0];
    out_next.inv_r0c1    = val[1];
    out_next.inv_r0c2    = val[2];
    out_next.inv_r1c0    = val[3];
    out_next.inv_r1c1    = val[4];
    out_next.inv_r1c2    = val[5];
    out_next.inv_r2c0    = val[6];
    out_next.inv_r2c1    = val[7];
    out_next.inv_r2c2    = val[8];
    out_next.determinant = fin.det_q;
    out_next.singular    = fin.sing;
    out_next.saturated   = fin.det_sat || (|satl);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= dvalid[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) out_data <= out_next;
  end

endmodule
`default_nettype wire

>>> design/mat3i_checker.sv
// port checker for the 3x3 inverse block, bound to the top level
`default_nettype none
`include "mat3_inverse_determinant_assert.svh"
module mat3i_checker import mat3i_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input mat_out_t         out_data
);

  // stalled result stays
  `MAT3I_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `MAT3I_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_data))

  // pipeline empty after reset
  `MAT3I_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)

  // singular result has an all-zero inverse
  `MAT3I_ASSERT_NOW(a_sing_zero, clk, rst, out_valid && out_data.singular,
    out_data.inv_r0c0 == 0 && out_data.inv_r0c1 == 0 && out_data.inv_r0c2 == 0 &&
    out_data.inv_r1c0 == 0 && out_data.inv_r1c1 == 0 && out_data.inv_r1c2 == 0 &&
    out_data.inv_r2c0 == 0 && out_data.inv_r2c1 == 0 && out_data.inv_r2c2 == 0)

  // singular and clipped means the determinant itself was clipped
  `MAT3I_ASSERT_NOW(a_sing_sat, clk, rst,
    out_valid && out_data.singular && out_data.saturated,
    out_data.determinant == 32'sh7FFFFFFF || out_data.determinant == 32'sh80000000)

endmodule

bind mat3_inverse_determinant mat3i_checker u_checker (.*);
`default_nettype wire
